FILE: rtl/nps_pkg.sv
// Shared types, constants and codes for the nearest-point search block.
package nps_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int COORD_BITS = 16;
  localparam int IDX_BITS   = $clog2(MAX_POINTS);
  localparam int CNT_BITS   = $clog2(MAX_POINTS + 1);
  localparam int SQ_BITS    = 2 * COORD_BITS;
  localparam int DIST_BITS  = SQ_BITS + 1;
  localparam int LOAD_IDX_W = 10;
  localparam int ENTRY_BITS = 2 * COORD_BITS;

  // Request commands
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic                  cmd;
    logic [LOAD_IDX_W-1:0] load_index;
    logic [COORD_BITS-1:0] coord_x;
    logic [COORD_BITS-1:0] coord_y;
  } in_t;

  typedef struct packed {
    logic                  found;
    logic [LOAD_IDX_W-1:0] nearest_index;
    logic [COORD_BITS-1:0] nearest_x;
    logic [COORD_BITS-1:0] nearest_y;
    logic [DIST_BITS-1:0]  distance_squared;
  } out_t;

  // Tag that travels alongside each table read through the distance unit
  typedef struct packed {
    logic                valid;
    logic                last;
    logic [IDX_BITS-1:0] index;
  } tag_t;

  // Candidate leaving the distance unit
  typedef struct packed {
    tag_t                  tag;
    logic [DIST_BITS-1:0]  dsq;
    logic [COORD_BITS-1:0] px;
    logic [COORD_BITS-1:0] py;
  } cand_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } state_t;

endpackage

FILE: rtl/nps_ram.sv
// Generic single-write, single-read RAM with registered read data.
module nps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/nps_dist_unit.sv
// Pipelined squared-distance unit shared by every table entry of a scan.
module nps_dist_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  nps_pkg::tag_t                  issue,
  input  logic [nps_pkg::ENTRY_BITS-1:0] entry,
  input  logic [nps_pkg::COORD_BITS-1:0] qx,
  input  logic [nps_pkg::COORD_BITS-1:0] qy,
  output nps_pkg::cand_t                 cand
);
  import nps_pkg::*;

  tag_t                  tag_rd;
  tag_t                  tag_a;
  tag_t                  tag_b;
  logic [COORD_BITS-1:0] px_rd;
  logic [COORD_BITS-1:0] py_rd;
  logic [COORD_BITS-1:0] px_a;
  logic [COORD_BITS-1:0] py_a;
  logic [COORD_BITS-1:0] px_b;
  logic [COORD_BITS-1:0] py_b;
  logic [COORD_BITS-1:0] dx_a;
  logic [COORD_BITS-1:0] dy_a;
  logic [SQ_BITS-1:0]    sqx_b;
  logic [SQ_BITS-1:0]    sqy_b;

  assign px_rd = entry[ENTRY_BITS-1:COORD_BITS];
  assign py_rd = entry[COORD_BITS-1:0];

  // Tag pipeline: align with read data, then follow the two stages
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_rd <= '0;
      tag_a  <= '0;
      tag_b  <= '0;
    end else begin
      tag_rd <= issue;
      tag_a  <= tag_rd;
      tag_b  <= tag_a;
    end
  end

  // Stage A: absolute differences
  always_ff @(posedge clk) begin
    px_a <= px_rd;
    py_a <= py_rd;
    dx_a <= (px_rd >= qx) ? (px_rd - qx) : (qx - px_rd);
    dy_a <= (py_rd >= qy) ? (py_rd - qy) : (qy - py_rd);
  end

  // Stage B: squares
  always_ff @(posedge clk) begin
    px_b  <= px_a;
    py_b  <= py_a;
    sqx_b <= SQ_BITS'(dx_a) * SQ_BITS'(dx_a);
    sqy_b <= SQ_BITS'(dy_a) * SQ_BITS'(dy_a);
  end

  // Sum of squares goes straight to the compare in the sequencer
  always_comb begin
    cand.tag = tag_b;
    cand.dsq = DIST_BITS'(sqx_b) + DIST_BITS'(sqy_b);
    cand.px  = px_b;
    cand.py  = py_b;
  end

endmodule

FILE: rtl/nps_seq.sv
// Scan sequencer, best-candidate tracking and result register.
module nps_seq (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  nps_pkg::in_t                   request,
  input  logic [nps_pkg::CNT_BITS-1:0]   point_count,
  input  nps_pkg::cand_t                 cand,
  output logic                           busy,
  output nps_pkg::tag_t                  issue,
  output logic [nps_pkg::COORD_BITS-1:0] qx,
  output logic [nps_pkg::COORD_BITS-1:0] qy,
  output nps_pkg::out_t                  result,
  output logic                           done
);
  import nps_pkg::*;

  state_t                st;
  state_t                st_next;
  logic [IDX_BITS-1:0]   idx;
  logic [IDX_BITS-1:0]   n_last;
  logic [CNT_BITS-1:0]   n_sat;
  logic                  have;
  logic [DIST_BITS-1:0]  best_d;
  logic [IDX_BITS-1:0]   best_i;
  logic [COORD_BITS-1:0] best_x;
  logic [COORD_BITS-1:0] best_y;
  logic                  accept_query;
  logic                  take;
  logic                  finish;
  logic [DIST_BITS-1:0]  nb_d;
  logic [IDX_BITS-1:0]   nb_i;
  logic [COORD_BITS-1:0] nb_x;
  logic [COORD_BITS-1:0] nb_y;

  // Clamp the scan length to the table depth
  assign n_sat = (point_count > CNT_BITS'(MAX_POINTS)) ? CNT_BITS'(MAX_POINTS) : point_count;

  assign busy         = (st != ST_IDLE);
  assign accept_query = start && !busy && (request.cmd == CMD_QUERY);

  // Running best including the candidate now at the compare
  assign take   = cand.tag.valid && (!have || (cand.dsq < best_d));
  assign nb_d   = take ? cand.dsq : best_d;
  assign nb_i   = take ? cand.tag.index : best_i;
  assign nb_x   = take ? cand.px : best_x;
  assign nb_y   = take ? cand.py : best_y;
  assign finish = cand.tag.valid && cand.tag.last;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_IDLE;
    end else begin
      st <= st_next;
    end
  end

  // Next state and read issue
  always_comb begin
    st_next     = st;
    issue.valid = 1'b0;
    issue.last  = 1'b0;
    issue.index = idx;
    unique case (st)
      ST_IDLE: begin
        if (accept_query && (n_sat != '0)) begin
          st_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        issue.valid = 1'b1;
        issue.last  = (idx == n_last);
        if (idx == n_last) begin
          st_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (finish) begin
          st_next = ST_IDLE;
        end
      end
      default: st_next = ST_IDLE;
    endcase
  end

  // Scan counter and query latch
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (accept_query) begin
      idx <= '0;
    end else if (st == ST_SCAN) begin
      idx <= idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept_query) begin
      qx     <= request.coord_x;
      qy     <= request.coord_y;
      n_last <= IDX_BITS'(n_sat - 1'b1);
    end
  end

  // Track the best candidate; only a strictly smaller distance replaces it
  always_ff @(posedge clk) begin
    if (rst) begin
      have <= 1'b0;
    end else if (accept_query) begin
      have <= 1'b0;
    end else if (cand.tag.valid) begin
      have <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    best_d <= nb_d;
    best_i <= nb_i;
    best_x <= nb_x;
    best_y <= nb_y;
  end

  // Result register and one-cycle strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (accept_query && (n_sat == '0)) || ((st == ST_DRAIN) && finish);
    end
  end

  always_ff @(posedge clk) begin
    if (accept_query && (n_sat == '0)) begin
      result <= '0;
    end else if ((st == ST_DRAIN) && finish) begin
      result.found            <= 1'b1;
      result.nearest_index    <= LOAD_IDX_W'(nb_i);
      result.nearest_x        <= nb_x;
      result.nearest_y        <= nb_y;
      result.distance_squared <= nb_d;
    end
  end

  // No candidate may reach the compare while the block is idle
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (st == ST_IDLE) |-> !cand.tag.valid)
    else $error("candidate in flight while idle");

  // The scan never runs past the last slot of the query
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (st == ST_SCAN) |-> (idx <= n_last))
    else $error("scan index beyond point count");

  // The final candidate of a scan produces a result on the next cycle
  a_last_done: assert property (@(posedge clk) disable iff (rst)
    ((st == ST_DRAIN) && finish) |=> (done && result.found))
    else $error("scan finished without a result");

  // A found slot lies inside the scanned range
  a_found_range: assert property (@(posedge clk) disable iff (rst)
    (done && result.found) |-> (IDX_BITS'(result.nearest_index) <= n_last))
    else $error("nearest slot outside scanned range");

endmodule

FILE: rtl/nearest_point_linear_search.sv
// A query over n points (n = point_count, capped at the table depth) issues its reads in order
// through the RAM read register and stages A and B; the next request can be taken while done is high.
// A query over an empty table answers with found low on the next cycle; busy drops any load.
// The scan reads one table entry per cycle from the single RAM read port into one distance unit.
// Reset (rst, synchronous) clears point_count and the sequencer; the table is unset until loaded.
// Results appear on result for one cycle marked by done; the receiver cannot stall them.
module nearest_point_linear_search (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  nps_pkg::in_t                 request,
  output nps_pkg::out_t                result,
  output logic                         done,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [nps_pkg::CNT_BITS-1:0] cfg_data
);
  import nps_pkg::*;

  logic [CNT_BITS-1:0]   point_count;
  logic                  load_we;
  logic [ENTRY_BITS-1:0] entry;
  tag_t                  issue;
  cand_t                 cand;
  logic [COORD_BITS-1:0] qx;
  logic [COORD_BITS-1:0] qy;

  // Configuration register, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= '0;
    end else if (cfg_valid && cfg_ready) begin
      point_count <= cfg_data;
    end
  end

  // Write a loaded point straight into the table
  assign load_we = start && !busy && (request.cmd == CMD_LOAD) &&
                   (32'(request.load_index) < MAX_POINTS);

  nps_ram #(
    .WIDTH(ENTRY_BITS),
    .DEPTH(MAX_POINTS)
  ) u_table (
    .clk  (clk),
    .we   (load_we),
    .waddr(request.load_index[IDX_BITS-1:0]),
    .wdata({request.coord_x, request.coord_y}),
    .raddr(issue.index),
    .rdata(entry)
  );

  nps_dist_unit u_dist (
    .clk  (clk),
    .rst  (rst),
    .issue(issue),
    .entry(entry),
    .qx   (qx),
    .qy   (qy),
    .cand (cand)
  );

  nps_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .request    (request),
    .point_count(point_count),
    .cand       (cand),
    .busy       (busy),
    .issue      (issue),
    .qx         (qx),
    .qy         (qy),
    .result     (result),
    .done       (done)
  );

endmodule
